/* rtl/bucket_hash_table_probe_defines.svh */
// Assertion macros for the bucketed hash table probe.
// Used by the top level only; every macro samples on clk and is disabled in rst.
`ifndef BUCKET_HASH_TABLE_PROBE_DEFINES_SVH
`define BUCKET_HASH_TABLE_PROBE_DEFINES_SVH

// Same-cycle implication.
`define BHTP_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BHTP_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/bhtp_pkg.sv */
// Shared constants, codes and types of the bucketed hash table probe.
// No dependencies; used by the remainder unit, the top level and the testbench.
package bhtp_pkg;

  // Table geometry.
  localparam int MAX_BUCKETS = 16;
  localparam int MAX_SLOTS   = 8;
  localparam int KEY_W  = 31;
  localparam int BKT_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int SLT_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int NB_W   = BKT_W + 1;
  localparam int NS_W   = SLT_W + 1;
  localparam int ROW_W  = MAX_SLOTS * KEY_W;

  // Field and register widths.
  localparam int BC_W     = 5;
  localparam int SC_W     = 4;
  localparam int REQ_W    = 2;
  localparam int ST_W     = 2;
  localparam int BIDX_W   = 4;
  localparam int SIDX_W   = 3;
  localparam int S_DATA_W = ((KEY_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((BIDX_W + SIDX_W + 7) / 8) * 8;
  localparam int CFG_W    = 32;
  localparam int PADDR_W  = 3;

  // Remainder unit: two dividend bits per cycle.
  localparam int DIV_STEPS = (KEY_W + 1) / 2;
  localparam int DIV_W     = 2 * DIV_STEPS;
  localparam int DIV_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  // Request kinds.
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
  localparam logic [ST_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

  // Register indexes, taken from paddr above the word offset.
  localparam logic REG_BUCKET_COUNT = 1'b0;
  localparam logic REG_SLOT_COUNT   = 1'b1;

  // Status of the remainder unit toward the sequencer.
  typedef struct packed {
    logic             done;
    logic [BKT_W-1:0] rem;
  } div_stat_t;

endpackage

/* rtl/bhtp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bhtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/bhtp_mod_unit.sv */
// Iterative remainder unit: key mod bucket count, two dividend bits per cycle.
// Depends on bhtp_pkg.
module bhtp_mod_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bhtp_pkg::KEY_W-1:0]  key,
  input  logic [bhtp_pkg::NB_W-1:0]   nb,
  output bhtp_pkg::div_stat_t         stat
);

  logic                            busy;
  logic                            done;
  logic [bhtp_pkg::DIV_CNT_W-1:0]  cnt;
  logic [bhtp_pkg::DIV_W-1:0]      dvd;
  logic [bhtp_pkg::BKT_W-1:0]      rem;
  logic [bhtp_pkg::NB_W-1:0]       t0;
  logic [bhtp_pkg::NB_W-1:0]       t1;
  logic [bhtp_pkg::BKT_W-1:0]      r1;
  logic [bhtp_pkg::BKT_W-1:0]      r2;

  // Two restoring steps: shift in a bit, subtract the divisor when it fits.
  always_comb begin
    t0 = {rem, dvd[bhtp_pkg::DIV_W-1]};
    r1 = (t0 >= nb) ? bhtp_pkg::BKT_W'(t0 - nb) : bhtp_pkg::BKT_W'(t0);
    t1 = {r1, dvd[bhtp_pkg::DIV_W-2]};
    r2 = (t1 >= nb) ? bhtp_pkg::BKT_W'(t1 - nb) : bhtp_pkg::BKT_W'(t1);
  end

  // Control: busy until the last step, then a one-cycle done.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + bhtp_pkg::DIV_CNT_W'(1);
        if (cnt == bhtp_pkg::DIV_CNT_W'(bhtp_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out at the top, partial remainder follows.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= bhtp_pkg::DIV_W'(key);
      rem <= '0;
    end else if (busy) begin
      dvd <= dvd << 2;
      rem <= r2;
    end
  end

  assign stat.done = done;
  assign stat.rem  = rem;

endmodule

/* rtl/bucket_hash_table_probe.sv */
// Bucketed hash table with linear probing over buckets. A request is taken on the
// slave stream when the block is idle; it answers with one result word on the master
// stream, held in an output register. Each insert, delete or search first computes
// key mod bucket count in the remainder unit, two key bits per cycle. An insert then
// checks one bucket fill count per cycle until it finds room, then reads that bucket
// row and writes it back; when no bucket in use has room it answers full. A delete or
// search reads one bucket row at a time, compares all its slots at once and stops at
// the first hit or after every bucket in use. The unused request code goes straight
// to the result without the remainder unit. A finished result waits while the output
// register still holds a word that has not been accepted, and the next request is
// taken in the cycle after the result word is loaded.
// Occupancy and fill counts are flip-flops cleared by reset, so the block is ready
// right after reset; key storage is a RAM holding one bucket row per entry.
// Depends on bhtp_pkg, bhtp_mod_unit, bhtp_ram and bucket_hash_table_probe_defines.svh.
`include "bucket_hash_table_probe_defines.svh"

module bucket_hash_table_probe (
  input  logic                            clk,
  input  logic                            rst,
  // Request stream.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [bhtp_pkg::S_DATA_W-1:0]   s_tdata,   // [30:0] key, [31] zero
  input  logic [bhtp_pkg::REQ_W-1:0]      s_tuser,   // [1:0] req_type
  // Result stream.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [bhtp_pkg::M_DATA_W-1:0]   m_tdata,   // [3:0] bucket_index, [6:4] slot_index
  output logic [bhtp_pkg::ST_W-1:0]       m_tuser,   // [1:0] status
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bhtp_pkg::PADDR_W-1:0]    paddr,
  input  logic [bhtp_pkg::CFG_W-1:0]      pwdata,
  output logic [bhtp_pkg::CFG_W-1:0]      prdata,
  output logic                            pready
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV  = 7'b0000010,
    S_FILL = 7'b0000100,
    S_RD   = 7'b0001000,
    S_CMP  = 7'b0010000,
    S_WR   = 7'b0100000,
    S_RESP = 7'b1000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [bhtp_pkg::BC_W-1:0] bucket_count;
  logic [bhtp_pkg::SC_W-1:0] slot_count;
  logic [bhtp_pkg::NB_W-1:0] nb;
  logic [bhtp_pkg::NS_W-1:0] ns;
  logic                      cfg_write;

  // Table state kept in flip-flops.
  logic [bhtp_pkg::MAX_BUCKETS-1:0][bhtp_pkg::MAX_SLOTS-1:0] occ;
  logic [bhtp_pkg::MAX_BUCKETS-1:0][bhtp_pkg::NS_W-1:0]      fill;

  // Request and walk registers.
  logic [bhtp_pkg::REQ_W-1:0] req;
  logic [bhtp_pkg::KEY_W-1:0] key;
  logic [bhtp_pkg::BKT_W-1:0] bkt;
  logic [bhtp_pkg::NB_W-1:0]  steps;
  logic [bhtp_pkg::SLT_W-1:0] slot;
  logic [bhtp_pkg::ST_W-1:0]  res_status;
  logic [bhtp_pkg::BKT_W-1:0] res_bkt;
  logic [bhtp_pkg::SLT_W-1:0] res_slot;

  // Output register.
  logic [bhtp_pkg::ST_W-1:0]   out_status;
  logic [bhtp_pkg::BIDX_W-1:0] out_bkt;
  logic [bhtp_pkg::SIDX_W-1:0] out_slot;

  // Walk helpers.
  logic                         s_accept;
  logic                         req_known;
  logic                         div_start;
  bhtp_pkg::div_stat_t          div_stat;
  logic [bhtp_pkg::NB_W-1:0]    bkt_plus;
  logic [bhtp_pkg::BKT_W-1:0]   bkt_wrap;
  logic                         last_step;
  logic                         out_free;
  logic [bhtp_pkg::MAX_SLOTS-1:0] in_use;
  logic [bhtp_pkg::MAX_SLOTS-1:0] free_vec;
  logic [bhtp_pkg::MAX_SLOTS-1:0] hit_vec;
  logic [bhtp_pkg::SLT_W-1:0]   free_idx;
  logic [bhtp_pkg::SLT_W-1:0]   hit_idx;
  logic                         room;
  logic [bhtp_pkg::ROW_W-1:0]   rd_row;
  logic [bhtp_pkg::ROW_W-1:0]   wr_row;
  logic                         row_we;
  logic                         walk_state;
  logic                         fill_match;

  // Counts in use, saturated into their legal ranges.
  always_comb begin
    if (bucket_count == '0) begin
      nb = bhtp_pkg::NB_W'(1);
    end else if (bucket_count > bhtp_pkg::BC_W'(bhtp_pkg::MAX_BUCKETS)) begin
      nb = bhtp_pkg::NB_W'(bhtp_pkg::MAX_BUCKETS);
    end else begin
      nb = bhtp_pkg::NB_W'(bucket_count);
    end
    if (slot_count == '0) begin
      ns = bhtp_pkg::NS_W'(1);
    end else if (slot_count > bhtp_pkg::SC_W'(bhtp_pkg::MAX_SLOTS)) begin
      ns = bhtp_pkg::NS_W'(bhtp_pkg::MAX_SLOTS);
    end else begin
      ns = bhtp_pkg::NS_W'(slot_count);
    end
  end

  // Configuration port: always ready, register index above the word offset.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[bhtp_pkg::PADDR_W-1])
      bhtp_pkg::REG_BUCKET_COUNT: prdata = bhtp_pkg::CFG_W'(bucket_count);
      bhtp_pkg::REG_SLOT_COUNT:   prdata = bhtp_pkg::CFG_W'(slot_count);
      default:                    prdata = '0;
    endcase
  end

  // Handshake and remainder unit start.
  assign s_tready  = (state == S_IDLE);
  assign s_accept  = s_tvalid && s_tready;
  assign req_known = (s_tuser == bhtp_pkg::REQ_INSERT) || (s_tuser == bhtp_pkg::REQ_DELETE) ||
                     (s_tuser == bhtp_pkg::REQ_SEARCH);
  assign div_start = s_accept && req_known;
  assign out_free  = !m_tvalid || m_tready;

  bhtp_mod_unit u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .key   (s_tdata[bhtp_pkg::KEY_W-1:0]),
    .nb    (nb),
    .stat  (div_stat)
  );

  // Next bucket on the walk, wrapping at the count in use.
  assign bkt_plus  = bhtp_pkg::NB_W'(bkt) + bhtp_pkg::NB_W'(1);
  assign bkt_wrap  = (bkt_plus == nb) ? '0 : bhtp_pkg::BKT_W'(bkt_plus);
  assign last_step = ((steps + bhtp_pkg::NB_W'(1)) == nb);

  // Slot match and free-slot search over the current bucket row.
  always_comb begin
    for (int s = 0; s < bhtp_pkg::MAX_SLOTS; s++) begin
      in_use[s]   = (bhtp_pkg::NS_W'(s) < ns);
      free_vec[s] = !occ[bkt][s] && in_use[s];
      hit_vec[s]  = occ[bkt][s] && in_use[s] &&
                    (rd_row[s*bhtp_pkg::KEY_W +: bhtp_pkg::KEY_W] == key);
    end
    free_idx = '0;
    hit_idx  = '0;
    for (int s = bhtp_pkg::MAX_SLOTS - 1; s >= 0; s--) begin
      if (free_vec[s]) begin
        free_idx = bhtp_pkg::SLT_W'(s);
      end
      if (hit_vec[s]) begin
        hit_idx = bhtp_pkg::SLT_W'(s);
      end
    end
    room = (fill[bkt] < ns) && (|free_vec);
  end

  // Row write-back for an insert: the new key replaces one slot.
  always_comb begin
    for (int s = 0; s < bhtp_pkg::MAX_SLOTS; s++) begin
      wr_row[s*bhtp_pkg::KEY_W +: bhtp_pkg::KEY_W] =
        (bhtp_pkg::SLT_W'(s) == slot) ? key : rd_row[s*bhtp_pkg::KEY_W +: bhtp_pkg::KEY_W];
    end
  end

  assign row_we = (state == S_WR);

  bhtp_ram #(
    .WIDTH (bhtp_pkg::ROW_W),
    .DEPTH (bhtp_pkg::MAX_BUCKETS)
  ) u_keys (
    .clk   (clk),
    .we    (row_we),
    .waddr (bkt),
    .wdata (wr_row),
    .raddr (bkt),
    .rdata (rd_row)
  );

  // Sequencer, table flags, configuration and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      m_tvalid     <= 1'b0;
      occ          <= '0;
      fill         <= '0;
      bucket_count <= bhtp_pkg::BC_W'(16);
      slot_count   <= bhtp_pkg::SC_W'(8);
    end else begin
      if (cfg_write) begin
        case (paddr[bhtp_pkg::PADDR_W-1])
          bhtp_pkg::REG_BUCKET_COUNT: bucket_count <= pwdata[bhtp_pkg::BC_W-1:0];
          bhtp_pkg::REG_SLOT_COUNT:   slot_count   <= pwdata[bhtp_pkg::SC_W-1:0];
          default: ;
        endcase
      end
      // A result word is loaded when the output register is free, else it drains.
      if ((state == S_RESP) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_accept) begin
            state <= req_known ? S_DIV : S_RESP;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= (req == bhtp_pkg::REQ_INSERT) ? S_FILL : S_RD;
          end
        end
        S_FILL: begin
          if (room) begin
            state <= S_RD;
          end else if (last_step) begin
            state <= S_RESP;
          end
        end
        S_RD: begin
          state <= (req == bhtp_pkg::REQ_INSERT) ? S_WR : S_CMP;
        end
        S_CMP: begin
          if (|hit_vec) begin
            state <= S_RESP;
            if (req == bhtp_pkg::REQ_DELETE) begin
              occ[bkt][hit_idx] <= 1'b0;
              if (fill[bkt] != '0) begin
                fill[bkt] <= fill[bkt] - bhtp_pkg::NS_W'(1);
              end
            end
          end else begin
            state <= last_step ? S_RESP : S_RD;
          end
        end
        S_WR: begin
          occ[bkt][slot] <= 1'b1;
          fill[bkt]      <= fill[bkt] + bhtp_pkg::NS_W'(1);
          state          <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Request, walk position and result words.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_accept) begin
          req        <= s_tuser;
          key        <= s_tdata[bhtp_pkg::KEY_W-1:0];
          res_status <= bhtp_pkg::ST_ABSENT;
          res_bkt    <= '0;
          res_slot   <= '0;
        end
      end
      S_DIV: begin
        bkt   <= div_stat.rem;
        steps <= '0;
      end
      S_FILL: begin
        if (room) begin
          slot <= free_idx;
        end else if (last_step) begin
          res_status <= bhtp_pkg::ST_FULL;
        end else begin
          bkt   <= bkt_wrap;
          steps <= steps + bhtp_pkg::NB_W'(1);
        end
      end
      S_CMP: begin
        if (|hit_vec) begin
          res_status <= bhtp_pkg::ST_DONE;
          res_bkt    <= bkt;
          res_slot   <= hit_idx;
        end else if (!last_step) begin
          bkt   <= bkt_wrap;
          steps <= steps + bhtp_pkg::NB_W'(1);
        end
      end
      S_WR: begin
        res_status <= bhtp_pkg::ST_DONE;
        res_bkt    <= bkt;
        res_slot   <= slot;
      end
      S_RESP: begin
        if (out_free) begin
          out_status <= res_status;
          out_bkt    <= bhtp_pkg::BIDX_W'(res_bkt);
          out_slot   <= bhtp_pkg::SIDX_W'(res_slot);
        end
      end
      default: ;
    endcase
  end

  assign m_tuser = out_status;
  assign m_tdata = {{(bhtp_pkg::M_DATA_W - bhtp_pkg::BIDX_W - bhtp_pkg::SIDX_W){1'b0}},
                    out_slot, out_bkt};

  // Checker terms: the walk states, where the bucket register is always set.
  assign walk_state = (state == S_FILL) || (state == S_RD) || (state == S_CMP);
  assign fill_match = (bhtp_pkg::NS_W'($countones(occ[bkt])) == fill[bkt]);

  // The probe walk never visits more buckets than are in use.
  `BHTP_CHECK(a_walk_bound, walk_state, steps < nb, "probe walk ran past the buckets in use")
  // The fill count of the bucket under the walk equals its number of occupied slots.
  `BHTP_CHECK(a_fill_count, walk_state || row_we, fill_match, "fill count disagrees with occupancy")
  // An accepted request closes the input until its result is out.
  `BHTP_NEXT(a_one_request, s_tvalid && s_tready, !s_tready, "request taken while another is in work")

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for bucket_hash_table_probe: streams insert, delete and search requests
// and checks every result word against a bucket table kept inside the testbench.
// Depends on bhtp_pkg and the RTL of the block; reads no files.
module tb_top;
  import bhtp_pkg::*;

  // The request code the block does not define.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int TABLE_DEPTH  = MAX_BUCKETS * MAX_SLOTS;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 100;
  localparam int REPORT_CAP   = 200;
  localparam int POOL_SIZE    = 24;

  typedef struct packed {
    logic [REQ_W-1:0] kind;
    logic [KEY_W-1:0] key;
  } request_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [BIDX_W-1:0] bucket;
    logic [SIDX_W-1:0] slot;
  } answer_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;   // [30:0] key, [31] zero
  logic [REQ_W-1:0]    s_tuser  = '0;   // [1:0] req_type
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;         // [3:0] bucket_index, [6:4] slot_index
  logic [ST_W-1:0]     m_tuser;         // [1:0] status
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [PADDR_W-1:0]  paddr    = '0;
  logic [CFG_W-1:0]    pwdata   = '0;
  logic [CFG_W-1:0]    prdata;
  logic                pready;

  bucket_hash_table_probe dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Table contents and register copies as the block should hold them.
  bit [KEY_W-1:0] stored_key  [TABLE_DEPTH];
  bit             stored_used [TABLE_DEPTH];
  int unsigned    bucket_fill_cnt [MAX_BUCKETS];
  bit [BC_W-1:0]  bucket_count_reg = 5'd16;
  bit [SC_W-1:0]  slot_count_reg   = 4'd8;

  request_t    pending_reqs[$];
  answer_t     answers_due[$];
  request_t    next_req;
  request_t    taken_req;
  answer_t     oldest_answer;
  int          fail_count   = 0;
  int          quiet_cycles = 0;
  int          burst_left   = 1;
  int          gap_left     = 0;
  int          burst_max    = 1;
  int          gap_max      = 0;
  bit [15:0]   ready_pattern = 16'hFFFF;
  bit [3:0]    ready_pos     = '0;

  function automatic int unsigned buckets_in_use();
    if (bucket_count_reg < 1) return 1;
    if (bucket_count_reg > MAX_BUCKETS) return MAX_BUCKETS;
    return bucket_count_reg;
  endfunction

  function automatic int unsigned slots_in_use();
    if (slot_count_reg < 1) return 1;
    if (slot_count_reg > MAX_SLOTS) return MAX_SLOTS;
    return slot_count_reg;
  endfunction

  // Applies one request to the table and returns the answer it must produce.
  function automatic answer_t probe_table(request_t rq);
    int unsigned nb, ns, b, s, pos, hit_pos;
    answer_t ans;
    nb = buckets_in_use();
    ns = slots_in_use();
    b = rq.key % nb;
    hit_pos = 0;
    ans = '0;
    ans.status = (rq.kind == REQ_INSERT) ? ST_FULL : ST_ABSENT;
    if (rq.kind == REQ_INSERT) begin
      // Skip full buckets; take the lowest free slot of the first one with room.
      for (int step = 0; step < nb; step++) begin
        if (ans.status != ST_DONE && bucket_fill_cnt[b] < ns) begin
          for (s = 0; s < ns; s++) begin
            pos = b * MAX_SLOTS + s;
            if (ans.status != ST_DONE && !stored_used[pos]) begin
              stored_key[pos]  = rq.key;
              stored_used[pos] = 1'b1;
              bucket_fill_cnt[b]++;
              ans.status = ST_DONE;
              ans.bucket = BIDX_W'(b);
              ans.slot   = SIDX_W'(s);
            end
          end
        end
        b = (b + 1 == nb) ? 0 : b + 1;
      end
    end else if (rq.kind == REQ_DELETE || rq.kind == REQ_SEARCH) begin
      // Walk the buckets in order until the first occupied slot holding the key.
      for (int step = 0; step < nb; step++) begin
        for (s = 0; s < ns; s++) begin
          pos = b * MAX_SLOTS + s;
          if (ans.status != ST_DONE && stored_used[pos] && stored_key[pos] == rq.key) begin
            ans.status = ST_DONE;
            ans.bucket = BIDX_W'(b);
            ans.slot   = SIDX_W'(s);
            hit_pos = pos;
          end
        end
        b = (b + 1 == nb) ? 0 : b + 1;
      end
      if (rq.kind == REQ_DELETE && ans.status == ST_DONE) begin
        stored_used[hit_pos] = 1'b0;
        if (bucket_fill_cnt[ans.bucket] > 0) bucket_fill_cnt[ans.bucket]--;
      end
    end
    return ans;
  endfunction

  task automatic flag_mismatch(string what, longint unsigned want, longint unsigned got);
    fail_count++;
    if (fail_count <= REPORT_CAP)
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
  endtask

  // Request driver: sends queued words in bursts with random gaps in between.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        taken_req.kind = s_tuser;
        taken_req.key  = s_tdata[KEY_W-1:0];
        answers_due.push_back(probe_table(taken_req));
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          next_req = pending_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= S_DATA_W'(next_req.key);
          s_tuser  <= next_req.kind;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, burst_max);
            gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure follows a rotating 16-bit pattern.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready  <= ready_pattern[ready_pos];
      ready_pos <= ready_pos + 1'b1;
    end
  end

  // Result monitor: compares each accepted word with the oldest expected answer.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (answers_due.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_CAP)
          $display("%0t: result word with none expected, status %0d", $time, m_tuser);
      end else begin
        oldest_answer = answers_due.pop_front();
        if (m_tuser !== oldest_answer.status)
          flag_mismatch("status", oldest_answer.status, m_tuser);
        if (m_tdata[BIDX_W-1:0] !== oldest_answer.bucket)
          flag_mismatch("bucket_index", oldest_answer.bucket, m_tdata[BIDX_W-1:0]);
        if (m_tdata[BIDX_W+SIDX_W-1:BIDX_W] !== oldest_answer.slot)
          flag_mismatch("slot_index", oldest_answer.slot, m_tdata[BIDX_W+SIDX_W-1:BIDX_W]);
      end
    end
  end

  // Watchdog: ends the run after too long without any accepted word or register access.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_request(logic [REQ_W-1:0] kind, logic [KEY_W-1:0] key);
    request_t rq;
    rq.kind = kind;
    rq.key  = key;
    pending_reqs.push_back(rq);
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || answers_due.size() != 0 || s_tvalid)
      @(posedge clk);
  endtask

  task automatic read_check(logic idx, int unsigned want);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== CFG_W'(want)) flag_mismatch("register readback", want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(logic idx, int unsigned value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_BUCKET_COUNT) bucket_count_reg = value[BC_W-1:0];
    else slot_count_reg = value[SC_W-1:0];
  endtask

  // Writes both registers with junk in the unused upper bits, then reads them back.
  task automatic set_geometry(int unsigned buckets, int unsigned slots);
    write_reg(REG_BUCKET_COUNT, ($urandom & ~32'h1F) | buckets);
    write_reg(REG_SLOT_COUNT, ($urandom & ~32'hF) | slots);
    read_check(REG_BUCKET_COUNT, buckets);
    read_check(REG_SLOT_COUNT, slots);
  endtask

  task automatic set_pacing(int gaps, int bursts, bit [15:0] pattern);
    gap_max       = gaps;
    burst_max     = bursts;
    ready_pattern = pattern | 16'h0001;
  endtask

  // Random requests, mostly on a small pool of keys so that searches and deletes hit.
  task automatic random_phase(int count);
    bit [KEY_W-1:0] pool [POOL_SIZE];
    bit [KEY_W-1:0] key;
    logic [REQ_W-1:0] kind;
    int unsigned nb, pick;
    nb = buckets_in_use();
    for (int i = 0; i < POOL_SIZE; i++) begin
      case (i % 4)
        0: pool[i] = KEY_W'($urandom);
        1: pool[i] = KEY_W'($urandom_range(0, 40));
        2: pool[i] = {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 40));
        default: pool[i] = pool[i-1] + KEY_W'(nb * $urandom_range(1, 3));
      endcase
    end
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      key  = ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, POOL_SIZE - 1)]
                                        : KEY_W'($urandom);
      if (pick < 45) kind = REQ_INSERT;
      else if (pick < 65) kind = REQ_DELETE;
      else if (pick < 95) kind = REQ_SEARCH;
      else kind = REQ_UNUSED;
      queue_request(kind, key);
    end
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset geometry: extremes of the key, absent keys, the unused code, duplicates
    // and a bucket that overflows into its neighbor.
    read_check(REG_BUCKET_COUNT, 16);
    read_check(REG_SLOT_COUNT, 8);
    set_pacing(0, 1, 16'hFFFF);
    queue_request(REQ_INSERT, '0);
    queue_request(REQ_INSERT, {KEY_W{1'b1}});
    queue_request(REQ_SEARCH, '0);
    queue_request(REQ_SEARCH, 31'h2AAAAAAA);
    queue_request(REQ_DELETE, '0);
    queue_request(REQ_DELETE, '0);
    queue_request(REQ_SEARCH, '0);
    queue_request(REQ_UNUSED, 31'h55555555);
    queue_request(REQ_INSERT, 31'd5);
    queue_request(REQ_INSERT, 31'd5);
    queue_request(REQ_SEARCH, 31'd5);
    queue_request(REQ_DELETE, 31'd5);
    queue_request(REQ_SEARCH, 31'd5);
    for (int i = 0; i < 9; i++) queue_request(REQ_INSERT, KEY_W'(3 + 16 * i));
    queue_request(REQ_DELETE, 31'd19);
    queue_request(REQ_INSERT, 31'd147);
    wait_idle();

    // Smallest table: the second insert finds it full.
    set_geometry(1, 1);
    set_pacing(5, 3, 16'($urandom));
    queue_request(REQ_INSERT, 31'd7);
    queue_request(REQ_INSERT, 31'd9);
    queue_request(REQ_SEARCH, 31'd9);
    queue_request(REQ_DELETE, 31'd7);
    queue_request(REQ_INSERT, 31'd9);
    queue_request(REQ_SEARCH, 31'd9);
    random_phase(60);

    // Register values outside the legal range saturate.
    set_geometry(0, 0);
    set_pacing(40, 2, 16'h0001);
    random_phase(60);

    set_geometry(31, 15);
    set_pacing(0, 1, 16'hFFFF);
    random_phase(80);

    set_geometry(16, 8);
    set_pacing(25, 6, 16'($urandom));
    random_phase(80);

    set_geometry(5, 3);
    set_pacing(2, 8, 16'hAAAA);
    random_phase(70);

    set_geometry(3, 8);
    set_pacing(60, 1, 16'($urandom));
    random_phase(60);

    set_geometry(16, 1);
    set_pacing(10, 4, 16'hFFFF);
    random_phase(70);

    set_geometry($urandom_range(0, 31), $urandom_range(0, 15));
    set_pacing(30, 5, 16'($urandom));
    random_phase(80);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
